### rtl/core/tlbl_pkg.sv
// tlbl_pkg: shared constants, state encoding and structs for the tlb lookup block
// depends on nothing; imported by tlbl_scan_alu, tlb_lookup_with_lru_fifo_replace and tb
`timescale 1ns / 1ps

package tlbl_pkg;

  localparam int ENTRIES    = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int PAGE_BITS  = 8;
  localparam int FRAME_BITS = 7;
  localparam int AGE_BITS   = 16;
  localparam int SEQ_BITS   = 16;
  localparam int KEY_BITS   = (AGE_BITS > SEQ_BITS) ? AGE_BITS : SEQ_BITS;

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_INSTALL = 1'b1;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one entry as seen by the scan unit
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic [AGE_BITS-1:0]  age;
    logic [SEQ_BITS-1:0]  seq;
  } entry_view_t;

  // scan unit verdict for the current entry
  typedef struct packed {
    logic                 match;
    logic [AGE_BITS-1:0]  age_next;
    logic [KEY_BITS-1:0]  key;
    logic                 better;
  } scan_res_t;

endpackage

### rtl/core/tlbl_scan_alu.sv
// tlbl_scan_alu: shared compare and age unit used once per entry during a scan
// depends on tlbl_pkg
`timescale 1ns / 1ps

module tlbl_scan_alu (
  input  logic                          policy,
  input  logic                          first,
  input  logic [tlbl_pkg::PAGE_BITS-1:0] req_page,
  input  logic [tlbl_pkg::KEY_BITS-1:0]  best_key,
  input  tlbl_pkg::entry_view_t         ent,
  output tlbl_pkg::scan_res_t           res
);
  import tlbl_pkg::*;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic [KEY_BITS-1:0] key;

  always_comb begin
    // victim key: stamp for fifo, age for lru
    if (policy == POLICY_FIFO) begin
      key = KEY_BITS'(ent.seq);
    end else begin
      key = KEY_BITS'(ent.age);
    end
    res.key   = key;
    res.match = ent.valid && (ent.page == req_page);
    // saturating age step
    if (ent.valid && (ent.age != AGE_MAX)) begin
      res.age_next = ent.age + AGE_BITS'(1);
    end else begin
      res.age_next = ent.age;
    end
    if (first) begin
      res.better = 1'b1;
    end else if (policy == POLICY_FIFO) begin
      res.better = key < best_key;
    end else begin
      res.better = key > best_key;
    end
  end

endmodule

### rtl/core/tlb_lookup_with_lru_fifo_replace.sv
// tlb_lookup_with_lru_fifo_replace: 32-entry fully associative tlb, lru or fifo replacement
// depends on tlbl_pkg and tlbl_scan_alu
`timescale 1ns / 1ps

// Fully associative TLB of 32 entries mapping page numbers to frame numbers.
// A lookup word (op 0) ages every valid entry by one (saturating), clears the
// age of the lowest numbered matching entry and returns hit, frame and slot.
// An install word (op 1) writes into the lowest numbered invalid entry; when
// all entries are valid it replaces the entry with the greatest age (policy 0,
// lru) or the smallest install stamp (policy 1, fifo), lowest index on ties,
// and reports the evicted page. One compare/age unit walks the entries one
// per cycle, so a word is accepted in the idle state, then scanned against
// all 32 entries, then committed as a registered result word. The input is
// not ready during that time; a result waiting on out_ready holds the
// commit step. Write replace_policy over the cfg port only while idle.

module tlb_lookup_with_lru_fifo_replace (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  // request words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [tlbl_pkg::PAGE_BITS-1:0]  vpn,
  input  logic [tlbl_pkg::FRAME_BITS-1:0] pfn,
  input  logic [tlbl_pkg::SEQ_BITS-1:0]   install_sequence,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [tlbl_pkg::FRAME_BITS-1:0] frame_out,
  output logic [tlbl_pkg::IDX_BITS-1:0]   slot,
  output logic                            evicted,
  output logic [tlbl_pkg::PAGE_BITS-1:0]  evicted_page
);
  import tlbl_pkg::*;

  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ENTRIES - 1);

  // entry storage: valid bits reset, payload only read once valid
  logic [ENTRIES-1:0]    ent_valid;
  logic [PAGE_BITS-1:0]  ent_page  [ENTRIES];
  logic [FRAME_BITS-1:0] ent_frame [ENTRIES];
  logic [AGE_BITS-1:0]   ent_age   [ENTRIES];
  logic [SEQ_BITS-1:0]   ent_seq   [ENTRIES];

  logic policy;

  state_t state, state_next;

  // captured request
  logic                  req_op;
  logic [PAGE_BITS-1:0]  req_page;
  logic [FRAME_BITS-1:0] req_frame;
  logic [SEQ_BITS-1:0]   req_seq;

  // scan bookkeeping
  logic [IDX_BITS-1:0]   idx;
  logic                  found;
  logic [FRAME_BITS-1:0] found_frame;
  logic [IDX_BITS-1:0]   found_slot;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_pos;
  logic [IDX_BITS-1:0]   best_idx;
  logic [KEY_BITS-1:0]   best_key;
  logic [PAGE_BITS-1:0]  best_page;

  logic        can_load;
  logic        accept;
  logic        scan_en;
  logic        commit;
  entry_view_t cur;
  scan_res_t   res;
  logic [IDX_BITS-1:0] wr_pos;

  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign cur.valid = ent_valid[idx];
  assign cur.page  = ent_page[idx];
  assign cur.age   = ent_age[idx];
  assign cur.seq   = ent_seq[idx];

  tlbl_scan_alu u_alu (
    .policy   (policy),
    .first    (idx == '0),
    .req_page (req_page),
    .best_key (best_key),
    .ent      (cur),
    .res      (res)
  );

  // install target: first free entry, else the chosen victim
  assign wr_pos = free_found ? free_pos : best_idx;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx == IDX_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    commit   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scan_en  = 1'b1;
      ST_DONE: commit   = can_load;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      policy    <= POLICY_LRU;
      ent_valid <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) policy <= cfg_data;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit && (req_op == OP_INSTALL)) ent_valid[wr_pos] <= 1'b1;
    end
  end

  // request capture and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op      <= op;
      req_page    <= vpn;
      req_frame   <= pfn;
      req_seq     <= install_sequence;
      idx         <= '0;
      found       <= 1'b0;
      found_frame <= '0;
      found_slot  <= '0;
      free_found  <= 1'b0;
      free_pos    <= '0;
    end
    if (scan_en) begin
      idx <= idx + IDX_BITS'(1);
      if (req_op == OP_LOOKUP) begin
        // age every valid entry, first match restarts at zero
        if (res.match && !found) begin
          found       <= 1'b1;
          found_frame <= ent_frame[idx];
          found_slot  <= idx;
          ent_age[idx] <= '0;
        end else begin
          ent_age[idx] <= res.age_next;
        end
      end else begin
        if (!cur.valid && !free_found) begin
          free_found <= 1'b1;
          free_pos   <= idx;
        end
        if (res.better) begin
          best_idx  <= idx;
          best_key  <= res.key;
          best_page <= cur.page;
        end
      end
    end
    if (commit) begin
      if (req_op == OP_LOOKUP) begin
        hit          <= found;
        frame_out    <= found_frame;
        slot         <= found_slot;
        evicted      <= 1'b0;
        evicted_page <= '0;
      end else begin
        hit          <= 1'b0;
        frame_out    <= '0;
        slot         <= wr_pos;
        evicted      <= !free_found;
        evicted_page <= free_found ? '0 : best_page;
        ent_page[wr_pos]  <= req_page;
        ent_frame[wr_pos] <= req_frame;
        ent_age[wr_pos]   <= '0;
        ent_seq[wr_pos]   <= req_seq;
      end
    end
  end

  // an accepted word always starts a scan from entry zero
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (idx == '0))
    else $error("scan did not start after accept");

  // the scan runs through every entry before committing
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (idx != IDX_LAST) |=> (state == ST_SCAN))
    else $error("scan left early");

  // a result is either a hit or an eviction, never both
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction in one result");

  // an install always leaves its slot valid
  a_install_valid: assert property (@(posedge clk) disable iff (rst)
    commit && (req_op == OP_INSTALL) |=> ent_valid[slot])
    else $error("installed slot not valid");

endmodule

### tb/tb.sv
// tb: self-checking testbench for the 32-entry tlb with lru / fifo replacement
// depends on tlbl_pkg and tlb_lookup_with_lru_fifo_replace; shadow tlb predicts every result word
`timescale 1ns / 1ps

module tb;
  import tlbl_pkg::*;

  // no handshake of any kind for this long means the block is hung
  localparam int STALL_LIMIT  = 2000;
  // covers a full scan and the commit step, with margin
  localparam int DRAIN_CYCLES = 40;

  // one expected result word
  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
    logic [IDX_BITS-1:0]   slot;
    logic                  evicted;
    logic [PAGE_BITS-1:0]  evicted_page;
  } xlate_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = POLICY_LRU;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_LOOKUP;
  logic [PAGE_BITS-1:0]  vpn = '0;
  logic [FRAME_BITS-1:0] pfn = '0;
  logic [SEQ_BITS-1:0]   install_sequence = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic [FRAME_BITS-1:0] frame_out;
  logic [IDX_BITS-1:0]   slot;
  logic                  evicted;
  logic [PAGE_BITS-1:0]  evicted_page;

  // shadow copy of the tlb contents and the policy register
  logic                  shadow_valid [ENTRIES];
  logic [PAGE_BITS-1:0]  shadow_page  [ENTRIES];
  logic [FRAME_BITS-1:0] shadow_frame [ENTRIES];
  logic [AGE_BITS-1:0]   shadow_age   [ENTRIES];
  logic [SEQ_BITS-1:0]   shadow_seq   [ENTRIES];
  logic                  shadow_policy;

  // translations still owed by the block, oldest first
  xlate_t pending_xlates [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int ready_hold  = 0;

  // knobs for the random traffic
  bit                   steady_source = 1'b0;
  bit                   steady_sink   = 1'b0;
  int                   install_pct   = 40;
  logic [PAGE_BITS-1:0] pool_base     = '0;
  logic [SEQ_BITS-1:0]  stamp         = '0;

  tlb_lookup_with_lru_fifo_replace uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .vpn              (vpn),
    .pfn              (pfn),
    .install_sequence (install_sequence),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .hit              (hit),
    .frame_out        (frame_out),
    .slot             (slot),
    .evicted          (evicted),
    .evicted_page     (evicted_page)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow tlb: applies one request word and returns the result word it owes
  function automatic xlate_t predict_xlate(input logic opc, input logic [PAGE_BITS-1:0] pg,
                                           input logic [FRAME_BITS-1:0] fr,
                                           input logic [SEQ_BITS-1:0] sq);
    xlate_t r;
    int     pos;
    bit     found;
    r     = '0;
    pos   = 0;
    found = 1'b0;
    if (opc == OP_LOOKUP) begin
      // every valid entry ages first, hit or miss, saturating at all ones
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && shadow_age[i] != {AGE_BITS{1'b1}})
          shadow_age[i] = shadow_age[i] + 1'b1;
      end
      // lowest numbered match wins when a page sits in several entries
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && shadow_valid[i] && shadow_page[i] == pg) begin
          found         = 1'b1;
          shadow_age[i] = '0;
          r.hit         = 1'b1;
          r.frame       = shadow_frame[i];
          r.slot        = IDX_BITS'(i);
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && !shadow_valid[i]) begin
          found = 1'b1;
          pos   = i;
        end
      end
      if (!found) begin
        // full: victim by policy, strict compare keeps the lowest index on ties
        for (int i = 1; i < ENTRIES; i++) begin
          if (shadow_policy == POLICY_FIFO) begin
            if (shadow_seq[i] < shadow_seq[pos]) pos = i;
          end else begin
            if (shadow_age[i] > shadow_age[pos]) pos = i;
          end
        end
        r.evicted      = 1'b1;
        r.evicted_page = shadow_page[pos];
      end
      // installs never age the other entries
      shadow_valid[pos] = 1'b1;
      shadow_page[pos]  = pg;
      shadow_frame[pos] = fr;
      shadow_age[pos]   = '0;
      shadow_seq[pos]   = sq;
      r.slot            = IDX_BITS'(pos);
    end
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (steady_source) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // present one request word, hold it until taken, then maybe idle
  task automatic send_request(input logic o, input logic [PAGE_BITS-1:0] pg,
                              input logic [FRAME_BITS-1:0] fr, input logic [SEQ_BITS-1:0] sq);
    int gap;
    in_valid         <= 1'b1;
    op               <= o;
    vpn              <= pg;
    pfn              <= fr;
    install_sequence <= sq;
    do @(posedge clk); while (!in_ready);
    pending_xlates.push_back(predict_xlate(o, pg, fr, sq));
    gap = pick_gap();
    // valid stays high across a zero gap so it is never lowered and raised in one step
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every owed result word has come back
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_xlates.size() != 0) @(posedge clk);
  endtask

  // policy register write; only called with the block idle
  task automatic write_policy(input logic p);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    shadow_policy = p;
  endtask

  // random traffic around a pool of 48 pages so hits, misses and evictions all happen
  task automatic send_random_items(input int count);
    logic                  o;
    logic [PAGE_BITS-1:0]  pg;
    logic [FRAME_BITS-1:0] fr;
    int                    roll;
    repeat (count) begin
      o = ($urandom_range(0, 99) < install_pct) ? OP_INSTALL : OP_LOOKUP;
      if ($urandom_range(0, 99) < 85)
        pg = pool_base + PAGE_BITS'($urandom_range(0, 47));
      else
        pg = PAGE_BITS'($urandom);
      fr = FRAME_BITS'($urandom);
      // stamps mostly count up, sometimes jump anywhere, sometimes repeat for fifo ties
      roll = $urandom_range(0, 99);
      if (roll < 80)
        stamp = stamp + 1'b1;
      else if (roll < 90)
        stamp = SEQ_BITS'($urandom);
      send_request(o, pg, fr, stamp);
    end
  endtask

  // empty tlb miss, field extremes, duplicate pages, frame ignored on lookup
  task automatic test_directed();
    write_policy(POLICY_LRU);
    send_request(OP_LOOKUP,  8'h00, 7'h00, 16'h0000);
    send_request(OP_INSTALL, 8'h00, 7'h00, 16'h0000);
    send_request(OP_INSTALL, 8'hff, 7'h7f, 16'hffff);
    send_request(OP_INSTALL, 8'haa, 7'h55, 16'h5555);
    send_request(OP_INSTALL, 8'h55, 7'h2a, 16'haaaa);
    send_request(OP_LOOKUP,  8'hff, 7'h00, 16'h0000);
    send_request(OP_LOOKUP,  8'h00, 7'h7f, 16'hffff);
    send_request(OP_LOOKUP,  8'h55, 7'h7f, 16'h1234);
    // same page again: the lookup must keep using the lower entry
    send_request(OP_INSTALL, 8'hff, 7'h03, 16'h0001);
    send_request(OP_LOOKUP,  8'hff, 7'h00, 16'h0000);
    // miss still ages everything
    send_request(OP_LOOKUP,  8'h7f, 7'h00, 16'h0000);
    send_request(OP_LOOKUP,  8'haa, 7'h00, 16'h0000);
  endtask

  task automatic test_lru_replacement();
    pool_base = PAGE_BITS'($urandom);
    send_random_items(550);
  endtask

  task automatic test_fifo_replacement();
    drain_requests();
    write_policy(POLICY_FIFO);
    pool_base = PAGE_BITS'($urandom);
    send_random_items(550);
  endtask

  // flip the policy on a full tlb; each switch waits for every result first
  task automatic test_policy_switching();
    for (int k = 0; k < 4; k++) begin
      drain_requests();
      write_policy((k % 2 == 0) ? POLICY_LRU : POLICY_FIFO);
      pool_base = PAGE_BITS'($urandom);
      send_random_items(100);
    end
  endtask

  // no idling on either side, install heavy so lru age ties pile up
  task automatic test_back_to_back();
    drain_requests();
    write_policy(POLICY_LRU);
    steady_source = 1'b1;
    steady_sink   = 1'b1;
    install_pct   = 70;
    pool_base     = PAGE_BITS'($urandom);
    send_random_items(440);
    steady_source = 1'b0;
    steady_sink   = 1'b0;
    install_pct   = 40;
  endtask

  // result side back pressure: short and long stalls, or always ready in steady mode
  always @(posedge clk) begin : sink_ready_gen
    int roll;
    if (steady_sink) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 8);
      end else if (roll < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 60);
      end
    end
  end

  // every accepted result word against the oldest owed translation
  always @(posedge clk) begin : xlate_checker
    xlate_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_xlates.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches = mismatches + 1;
      end else begin
        want = pending_xlates.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit);
          mismatches = mismatches + 1;
        end
        if (frame_out !== want.frame) begin
          $error("frame_out: expected %0d, actual %0d", want.frame, frame_out);
          mismatches = mismatches + 1;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot);
          mismatches = mismatches + 1;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, actual %0d", want.evicted, evicted);
          mismatches = mismatches + 1;
        end
        if (evicted_page !== want.evicted_page) begin
          $error("evicted_page: expected %0d, actual %0d", want.evicted_page, evicted_page);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // hang detection: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // shadow tlb matches the block's reset state
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_page[i]  = '0;
      shadow_frame[i] = '0;
      shadow_age[i]   = '0;
      shadow_seq[i]   = '0;
    end
    shadow_policy = POLICY_LRU;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_lru_replacement();
    test_fifo_replacement();
    test_policy_switching();
    test_back_to_back();

    // all words sent: collect the last results, then watch for strays
    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_xlates.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
